### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers. They expand to nothing when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// A property that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// The antecedent implies the consequent in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The antecedent implies the consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### hdl/tsbp_pkg.sv
// ----------------------------------------------------------------------------
// tsbp_pkg
// Types and constants shared by the pacer and its channel interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

package tsbp_pkg;

    localparam int CREDIT_W   = 56;
    localparam int RATE_W     = 32;
    localparam int LIMIT_W    = 40;
    localparam int COOL_W     = 32;
    localparam int COUNT_W    = 8;
    localparam int DUE_W      = 16;
    localparam int AHEAD_W    = 40;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 40;

    // One packet is 188 bytes; the credit is kept in 1/256-bit units.
    localparam int PKT_BITS   = 188 * 8;
    localparam int FRAC_BITS  = 8;
    localparam int PKT_PROD_W = COUNT_W + 11;

    // 1504 * 256 = 47 * 2^13, so credit / (1504 * 256) = (credit >> 13) / 47.
    localparam int DIV_SHIFT  = 13;
    localparam int DIV_ODD    = 47;
    localparam int QUOT_IN_W  = 22;
    localparam int RECIP_W    = 23;
    localparam int RECIP_SH   = 28;
    localparam logic [RECIP_W-1:0] RECIP_47 = 23'd5711393;
    // Quotients at or above 65536 start here.
    localparam logic [CREDIT_W-DIV_SHIFT-1:0] DUE_SAT_IN = 43'(DIV_ODD * 65536);

    localparam logic [COOL_W-1:0] COOLDOWN_RESET = 32'd30000;

    typedef enum logic {
        CMD_TICK    = 1'b0,
        CMD_ACCOUNT = 1'b1
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RATE_PER_TICK   = 3'd0,
        REG_STUFF_ENABLE    = 3'd1,
        REG_THROTTLE_ENABLE = 3'd2,
        REG_OVERAGE_LIMIT   = 3'd3,
        REG_ALERT_COOLDOWN  = 3'd4
    } t_reg_idx;

endpackage

`default_nettype wire

### hdl/tsbp_if.sv
// ----------------------------------------------------------------------------
// tsbp channel interfaces
// Valid/ready channels for input items, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface tsbp_in_if;
    logic                          valid;
    logic                          ready;
    logic                          command;
    logic [tsbp_pkg::COUNT_W-1:0]  packet_count;

    modport source (output valid, output command, output packet_count, input ready);
    modport sink   (input valid, input command, input packet_count, output ready);
endinterface

interface tsbp_out_if;
    logic                          valid;
    logic                          ready;
    logic [tsbp_pkg::DUE_W-1:0]    stuff_due;
    logic [tsbp_pkg::AHEAD_W-1:0]  ahead_bits;
    logic                          throttle;
    logic                          overage_alert;

    modport source (output valid, output stuff_due, output ahead_bits, output throttle,
                    output overage_alert, input ready);
    modport sink   (input valid, input stuff_due, input ahead_bits, input throttle,
                    input overage_alert, output ready);
endinterface

interface tsbp_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [tsbp_pkg::CFG_IDX_W-1:0]  index;
    logic [tsbp_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### hdl/ts_bitrate_pacer.sv
// ----------------------------------------------------------------------------
// ts_bitrate_pacer
// Credit-based pacer for a 188-byte transport-stream output.
// ----------------------------------------------------------------------------
// Usage: every beat on i_in is either a time tick (command 0), which adds the
// configured rate to a signed 56-bit credit, or an account beat (command 1),
// which removes packet_count * 1504 bits from it. Every input beat yields one
// result beat on o_out with the null packets due, the bits sent ahead of
// schedule, a throttle flag and an overage alert. Registers are written over
// i_cfg, which is always ready; writes are meant for idle periods only.
// The credit register takes the sum when a beat is accepted, and the result
// register is loaded from it in turn. Throughput is one beat per cycle while
// o_out.ready stays high, set by the credit add and saturate loop.
// When the receiver stalls, the result register holds its beat; one more input
// beat is still taken into the credit stage, after which i_in.ready drops
// until the result is taken. Reset clears the credit, the cooldown counter and
// all valid flags and loads the registers with their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module ts_bitrate_pacer (
    input  wire        i_clk,
    input  wire        i_rst_n,
    tsbp_in_if.sink    i_in,
    tsbp_out_if.source o_out,
    tsbp_cfg_if.sink   i_cfg
);
    import tsbp_pkg::*;

    // Configuration registers.
    logic [RATE_W-1:0]  r_rate;
    logic               r_stuff_en;
    logic               r_throttle_en;
    logic [LIMIT_W-1:0] r_limit;
    logic [COOL_W-1:0]  r_cool_cfg;

    // Stage one: the running credit doubles as the payload of this stage.
    logic                       r_s1_valid;
    logic                       r_s1_cmd;
    logic signed [CREDIT_W-1:0] r_credit;

    // Stage two: alert state and the result register.
    logic [COOL_W-1:0]  r_cooldown;
    logic               r_alerted;
    logic               r_out_valid;
    logic [DUE_W-1:0]   r_due;
    logic [AHEAD_W-1:0] r_ahead;
    logic               r_throttle;
    logic               r_alert;

    logic in_acc;
    logic s2_adv;
    logic rate_on;

    assign rate_on = (r_rate != '0);
    assign s2_adv  = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s2_adv;
    assign in_acc  = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    // ---------------------------------------------------------------------
    // Configuration writes; an index beyond the list is ignored.
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate        <= '0;
            r_stuff_en    <= 1'b0;
            r_throttle_en <= 1'b0;
            r_limit       <= '0;
            r_cool_cfg    <= COOLDOWN_RESET;
        end else if (i_cfg.valid) begin
            case (t_reg_idx'(i_cfg.index))
                REG_RATE_PER_TICK:   r_rate        <= i_cfg.data[RATE_W-1:0];
                REG_STUFF_ENABLE:    r_stuff_en    <= i_cfg.data[0];
                REG_THROTTLE_ENABLE: r_throttle_en <= i_cfg.data[0];
                REG_OVERAGE_LIMIT:   r_limit       <= i_cfg.data[LIMIT_W-1:0];
                REG_ALERT_COOLDOWN:  r_cool_cfg    <= i_cfg.data[COOL_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Credit update: one 57-bit add, then saturation to the 56-bit range.
    // ---------------------------------------------------------------------
    logic [PKT_PROD_W-1:0]      pkt_bits;
    logic signed [CREDIT_W:0]   delta;
    logic signed [CREDIT_W:0]   sum_wide;
    logic signed [CREDIT_W-1:0] n_credit;

    always_comb begin
        pkt_bits = PKT_PROD_W'(i_in.packet_count) * PKT_PROD_W'(PKT_BITS);
        if (i_in.command == CMD_ACCOUNT) begin
            delta = -$signed({{(CREDIT_W+1-PKT_PROD_W-FRAC_BITS){1'b0}}, pkt_bits,
                              {FRAC_BITS{1'b0}}});
        end else begin
            delta = $signed({{(CREDIT_W+1-RATE_W){1'b0}}, r_rate});
        end
        sum_wide = {r_credit[CREDIT_W-1], r_credit} + delta;
        if (sum_wide[CREDIT_W] != sum_wide[CREDIT_W-1]) begin
            // Overflow: clamp to the most negative or most positive credit.
            n_credit = sum_wide[CREDIT_W] ? {1'b1, {(CREDIT_W-1){1'b0}}}
                                          : {1'b0, {(CREDIT_W-1){1'b1}}};
        end else begin
            n_credit = sum_wide[CREDIT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_credit   <= '0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
                r_credit   <= n_credit;
            end else if (s2_adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_cmd <= i_in.command;
        end
    end

    // ---------------------------------------------------------------------
    // Result logic on the stored credit.
    // ---------------------------------------------------------------------
    logic [CREDIT_W-1:0]          neg_credit;
    logic [AHEAD_W-1:0]           ahead_sat;
    logic [AHEAD_W-1:0]           n_ahead;
    logic [CREDIT_W-DIV_SHIFT-1:0] quot_in;
    logic [QUOT_IN_W+RECIP_W-1:0] quot_prod;
    logic [DUE_W-1:0]             n_due;
    logic                         cred_pos;
    logic                         n_alert;
    logic [COOL_W-1:0]            n_cooldown;

    always_comb begin
        // Bits ahead: floor(-credit / 256), saturated to 40 bits.
        neg_credit = ~r_credit + 1'b1;
        if (|neg_credit[CREDIT_W-1:FRAC_BITS+AHEAD_W]) begin
            ahead_sat = '1;
        end else begin
            ahead_sat = neg_credit[FRAC_BITS+AHEAD_W-1:FRAC_BITS];
        end
        n_ahead = (rate_on && r_credit[CREDIT_W-1]) ? ahead_sat : '0;

        // Null packets due, via a reciprocal multiply by 1/47.
        cred_pos  = !r_credit[CREDIT_W-1] && (r_credit != '0);
        quot_in   = r_credit[CREDIT_W-1:DIV_SHIFT];
        quot_prod = quot_in[QUOT_IN_W-1:0] * RECIP_47;
        if (!(r_stuff_en && rate_on && cred_pos)) begin
            n_due = '0;
        end else if (quot_in >= DUE_SAT_IN) begin
            n_due = '1;
        end else begin
            n_due = quot_prod[RECIP_SH+DUE_W-1:RECIP_SH];
        end

        // Alert and cooldown follow the items in order.
        n_alert    = 1'b0;
        n_cooldown = r_cooldown;
        if (r_s1_cmd == CMD_ACCOUNT) begin
            if (rate_on && (n_ahead > r_limit) && (!r_alerted || (r_cooldown == '0))) begin
                n_alert    = 1'b1;
                n_cooldown = r_cool_cfg;
            end
        end else if (r_cooldown != '0) begin
            n_cooldown = r_cooldown - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_cooldown  <= '0;
            r_alerted   <= 1'b0;
        end else begin
            if (s2_adv) begin
                r_out_valid <= 1'b1;
                r_cooldown  <= n_cooldown;
                if (n_alert) begin
                    r_alerted <= 1'b1;
                end
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_adv) begin
            r_due      <= n_due;
            r_ahead    <= n_ahead;
            r_throttle <= r_throttle_en && rate_on && r_credit[CREDIT_W-1];
            r_alert    <= n_alert;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.stuff_due     = r_due;
    assign o_out.ahead_bits    = r_ahead;
    assign o_out.throttle      = r_throttle;
    assign o_out.overage_alert = r_alert;

    // ---------------------------------------------------------------------
    // Assertions.
    // ---------------------------------------------------------------------
`include "assert_macros.svh"

    `ASSERT_IMPLY(a_ready_when_empty, i_clk, i_rst_n, !r_s1_valid, i_in.ready)
    `ASSERT_NEXT(a_stall_holds_credit, i_clk, i_rst_n, r_s1_valid && !s2_adv, r_s1_valid && $stable(r_credit))
    `ASSERT_NEXT(a_alert_loads_cooldown, i_clk, i_rst_n, s2_adv && n_alert, r_cooldown == $past(r_cool_cfg) && r_alerted)
    `ASSERT_IMPLY(a_stuff_excludes_throttle, i_clk, i_rst_n, o_out.valid && (o_out.stuff_due != '0), !o_out.throttle && (o_out.ahead_bits == '0))

endmodule

`default_nettype wire

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb: ts_bitrate_pacer testbench
// Drives tick and account beats into the pacer with random gaps, takes its
// results with random stalls, and compares every result field against a
// credit predictor kept inside the bench. Register settings change between
// phases while the pacer is idle.
// ----------------------------------------------------------------------------

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tsbp_pkg::*;

    // One packet in credit units (1504 bits, 1/256-bit resolution).
    localparam longint UNITS_PER_PKT = longint'(PKT_BITS) << FRAC_BITS;
    localparam longint CREDIT_TOP    = (longint'(1) << (CREDIT_W - 1)) - 1;
    localparam longint CREDIT_BOTTOM = -CREDIT_TOP - 1;
    localparam longint AHEAD_TOP     = (longint'(1) << AHEAD_W) - 1;
    localparam longint DUE_TOP       = (longint'(1) << DUE_W) - 1;

    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 217;
    localparam int MAX_GAP         = 14;
    localparam int DRAIN_CYCLES    = 8;
    localparam int CYCLE_LIMIT     = 600000;

    typedef struct packed {
        t_cmd               cmd;
        logic [COUNT_W-1:0] count;
    } t_pace_item;

    typedef struct packed {
        logic [DUE_W-1:0]   stuff_due;
        logic [AHEAD_W-1:0] ahead_bits;
        logic               throttle;
        logic               overage_alert;
    } t_pace_result;

    logic i_clk;
    logic i_rst_n;

    tsbp_in_if  in_if ();
    tsbp_out_if out_if ();
    tsbp_cfg_if cfg_if ();

    ts_bitrate_pacer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // Beats waiting to be driven, and the results that accepted beats owe us.
    t_pace_item   pending_items[$];
    t_pace_result expected_results[$];

    // Shadow of the pacer: its credit, alert cooldown and register copies.
    longint           credit_units = 0;
    logic [COOL_W-1:0] cool_left   = '0;
    logic              alert_seen  = 1'b0;
    logic [RATE_W-1:0]  cfg_rate     = '0;
    logic               cfg_stuff    = 1'b0;
    logic               cfg_throttle = 1'b0;
    logic [LIMIT_W-1:0] cfg_limit    = '0;
    logic [COOL_W-1:0]  cfg_cooldown = COOLDOWN_RESET;

    // Bookkeeping for the end-of-run report.
    int unsigned errors       = 0;
    int unsigned tick_beats   = 0;
    int unsigned acct_beats   = 0;
    int unsigned results_seen = 0;
    int unsigned alerts_seen  = 0;
    int unsigned throttled    = 0;
    int unsigned due_capped   = 0;
    int unsigned cycle_count  = 0;

    // Driver and monitor pacing state.
    int unsigned in_gap    = 0;
    logic        in_burst  = 1'b0;
    int unsigned out_stall = 0;
    logic        out_burst = 1'b0;
    t_pace_item   next_item;
    t_pace_item   taken_item;
    t_pace_result want;

    // ------------------------------------------------------------------------
    // Credit predictor
    // ------------------------------------------------------------------------

    // The credit register is 56 bits wide and sticks at either rail.
    function automatic longint credit_clamp(input longint v);
        if (v > CREDIT_TOP) begin
            return CREDIT_TOP;
        end
        if (v < CREDIT_BOTTOM) begin
            return CREDIT_BOTTOM;
        end
        return v;
    endfunction

    // Whole bits sent beyond schedule; zero when pacing is off or we are behind.
    function automatic longint bits_ahead_now();
        longint a;
        if (cfg_rate == '0 || credit_units >= 0) begin
            return 0;
        end
        a = (-credit_units) >> FRAC_BITS;
        return (a > AHEAD_TOP) ? AHEAD_TOP : a;
    endfunction

    // Apply one beat to the shadow state and return the result it must produce.
    function automatic t_pace_result pace_step(input t_pace_item item);
        longint       ahead;
        longint       due;
        t_pace_result r;
        r = '0;
        if (item.cmd == CMD_ACCOUNT) begin
            credit_units = credit_clamp(credit_units - longint'(item.count) * UNITS_PER_PKT);
            ahead = bits_ahead_now();
            // The very first alert ignores the cooldown; later ones wait it out.
            if (cfg_rate != '0 && ahead > longint'(cfg_limit) &&
                (!alert_seen || cool_left == '0)) begin
                r.overage_alert = 1'b1;
                alert_seen      = 1'b1;
                cool_left       = cfg_cooldown;
            end
        end else begin
            credit_units = credit_clamp(credit_units + longint'(cfg_rate));
            // The cooldown runs down on every tick, even with pacing disabled.
            if (cool_left != '0) begin
                cool_left = cool_left - 1'b1;
            end
        end
        r.ahead_bits = AHEAD_W'(bits_ahead_now());
        if (cfg_stuff && cfg_rate != '0 && credit_units > 0) begin
            due         = credit_units / UNITS_PER_PKT;
            r.stuff_due = (due > DUE_TOP) ? '1 : DUE_W'(due);
        end
        r.throttle = cfg_throttle && cfg_rate != '0 && credit_units < 0;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Clock, watchdog
    // ------------------------------------------------------------------------

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // A hung handshake or a lost result ends here instead of running forever.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Input driver
    // ------------------------------------------------------------------------
    // Each accepted beat is run through the predictor at the edge that takes
    // it, so expectations line up with the order the pacer sees its input.
    // Between beats the driver holds valid low for a random gap; now and then
    // it flips into a burst mode where beats go back to back.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                taken_item.cmd   = t_cmd'(in_if.command);
                taken_item.count = in_if.packet_count;
                expected_results.push_back(pace_step(taken_item));
                if (taken_item.cmd == CMD_ACCOUNT) begin
                    acct_beats++;
                end else begin
                    tick_beats++;
                end
            end
            // Only move on once the current beat has gone (or none is up).
            if (!in_if.valid || in_if.ready) begin
                if (in_gap != 0) begin
                    in_gap--;
                    in_if.valid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    next_item = pending_items.pop_front();
                    in_if.valid        <= 1'b1;
                    in_if.command      <= next_item.cmd;
                    in_if.packet_count <= next_item.count;
                    if ($urandom_range(0, 19) == 0) begin
                        in_burst = !in_burst;
                    end
                    in_gap = in_burst ? 0 : $urandom_range(0, MAX_GAP);
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------------
    // Every result beat is matched against the oldest expectation. After each
    // taken beat the receiver draws a random stall and keeps ready low while it
    // counts the stall down, which backs pressure up into the credit stage.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (expected_results.size() == 0) begin
                    $error("result beat arrived with no expectation waiting");
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    results_seen++;
                    if (out_if.stuff_due !== want.stuff_due) begin
                        $error("stuff_due: expected %0d, actual %0d",
                               want.stuff_due, out_if.stuff_due);
                        errors++;
                    end
                    if (out_if.ahead_bits !== want.ahead_bits) begin
                        $error("ahead_bits: expected %0d, actual %0d",
                               want.ahead_bits, out_if.ahead_bits);
                        errors++;
                    end
                    if (out_if.throttle !== want.throttle) begin
                        $error("throttle: expected %0b, actual %0b",
                               want.throttle, out_if.throttle);
                        errors++;
                    end
                    if (out_if.overage_alert !== want.overage_alert) begin
                        $error("overage_alert: expected %0b, actual %0b",
                               want.overage_alert, out_if.overage_alert);
                        errors++;
                    end
                    if (want.overage_alert) begin
                        alerts_seen++;
                    end
                    if (want.throttle) begin
                        throttled++;
                    end
                    if (want.stuff_due == '1) begin
                        due_capped++;
                    end
                end
                if ($urandom_range(0, 19) == 0) begin
                    out_burst = !out_burst;
                end
                out_stall = out_burst ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (out_stall != 0) begin
                out_stall--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequencing helpers
    // ------------------------------------------------------------------------

    function automatic void queue_item(input t_cmd cmd, input int count);
        t_pace_item item;
        item.cmd   = cmd;
        item.count = COUNT_W'(count);
        pending_items.push_back(item);
    endfunction

    // Idle means nothing left to send, nothing on the wire and nothing owed.
    // Checked on the falling edge so the clocked blocks have settled.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_items.size() != 0 || in_if.valid || expected_results.size() != 0);
    endtask

    // Must be entered right at a rising edge. Valid stays up on return so that
    // back-to-back writes never lower and raise it within one edge.
    task automatic write_reg(input t_reg_idx idx, input logic [CFG_DATA_W-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge i_clk);
        while (!cfg_if.ready);
        case (idx)
            REG_RATE_PER_TICK:   cfg_rate     = value[RATE_W-1:0];
            REG_STUFF_ENABLE:    cfg_stuff    = value[0];
            REG_THROTTLE_ENABLE: cfg_throttle = value[0];
            REG_OVERAGE_LIMIT:   cfg_limit    = value[LIMIT_W-1:0];
            REG_ALERT_COOLDOWN:  cfg_cooldown = value[COOL_W-1:0];
            default: ;
        endcase
    endtask

    // Rewrite every register once the pacer has drained.
    task automatic configure(input logic [RATE_W-1:0] rate, input logic stuff,
                             input logic thr, input logic [LIMIT_W-1:0] limit,
                             input logic [COOL_W-1:0] cool);
        wait_idle();
        @(posedge i_clk);
        write_reg(REG_RATE_PER_TICK, CFG_DATA_W'(rate));
        write_reg(REG_STUFF_ENABLE, CFG_DATA_W'(stuff));
        write_reg(REG_THROTTLE_ENABLE, CFG_DATA_W'(thr));
        write_reg(REG_OVERAGE_LIMIT, CFG_DATA_W'(limit));
        write_reg(REG_ALERT_COOLDOWN, CFG_DATA_W'(cool));
        cfg_if.valid <= 1'b0;
    endtask

    // Random beats that mostly steer the credit toward a target, so it keeps
    // crossing zero (or the null-packet cap) instead of running off to a rail.
    // About a third of the beats ignore the steering. Tick beats carry random
    // packet counts too, since the pacer must ignore that field for them.
    task automatic queue_random_items(input longint target);
        longint     plan;
        longint     cnt_hi;
        t_pace_item item;
        plan   = credit_units;
        cnt_hi = (longint'(cfg_rate) / UNITS_PER_PKT) * 2 + 3;
        if (cnt_hi > 255) begin
            cnt_hi = 255;
        end
        repeat (ITEMS_PER_PHASE) begin
            if ($urandom_range(0, 99) < 70) begin
                item.cmd = (plan > target) ? CMD_ACCOUNT : CMD_TICK;
            end else begin
                item.cmd = t_cmd'($urandom_range(0, 1));
            end
            if ($urandom_range(0, 9) == 0) begin
                item.count = COUNT_W'($urandom_range(0, 255));
            end else begin
                item.count = COUNT_W'($urandom_range(0, int'(cnt_hi)));
            end
            if (item.cmd == CMD_ACCOUNT) begin
                plan = plan - longint'(item.count) * UNITS_PER_PKT;
            end else begin
                plan = plan + longint'(cfg_rate);
            end
            pending_items.push_back(item);
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------

    logic [RATE_W-1:0]  ph_rate;
    logic               ph_stuff;
    logic               ph_thr;
    logic [LIMIT_W-1:0] ph_limit;
    logic [COOL_W-1:0]  ph_cool;
    longint             ph_target;

    initial begin
        in_if.valid        = 1'b0;
        in_if.command      = CMD_TICK;
        in_if.packet_count = '0;
        out_if.ready       = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.index       = REG_RATE_PER_TICK;
        cfg_if.data        = '0;
        i_rst_n            = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Out of reset the rate is zero: every field must read zero, while the
        // account beats still pull the credit down by the full packet count.
        queue_item(CMD_TICK, 255);
        queue_item(CMD_ACCOUNT, 255);
        queue_item(CMD_ACCOUNT, 0);
        queue_item(CMD_TICK, 0);

        // One packet per tick, zero limit and a two-tick cooldown. We start
        // far ahead, so the first account alerts, the next two are held off
        // by the cooldown, and once two ticks have run it down a third fires.
        configure(RATE_W'(UNITS_PER_PKT), 1'b1, 1'b1, '0, 2);
        queue_item(CMD_ACCOUNT, 0);
        queue_item(CMD_ACCOUNT, 1);
        queue_item(CMD_TICK, 0);
        queue_item(CMD_ACCOUNT, 0);
        queue_item(CMD_TICK, 0);
        queue_item(CMD_ACCOUNT, 0);

        // Largest limit: a big account sends us further ahead with no alert.
        // A fast rate with a fractional part then pulls the credit back up
        // through zero so null packets become due.
        configure(RATE_W'(UNITS_PER_PKT * 200 + 37), 1'b1, 1'b1, '1, '0);
        queue_item(CMD_ACCOUNT, 255);
        queue_item(CMD_TICK, 0);
        queue_item(CMD_TICK, 0);
        queue_item(CMD_TICK, 0);

        // With stuffing and throttling off, neither flag shows on either side.
        configure(RATE_W'(UNITS_PER_PKT * 200 + 37), 1'b0, 1'b0, '1, '0);
        queue_item(CMD_ACCOUNT, 200);
        queue_item(CMD_TICK, 0);

        // Random phases. Half draw their settings at random; the others are pinned
        // to the corners. The full-rate, full-cooldown phase goes last since
        // it leaves the credit far behind and the cooldown loaded for good.
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            ph_rate   = RATE_W'($urandom_range(1, int'(4 * UNITS_PER_PKT)));
            ph_stuff  = 1'($urandom_range(0, 1));
            ph_thr    = 1'($urandom_range(0, 1));
            ph_limit  = LIMIT_W'($urandom_range(0, 6000));
            ph_cool   = COOL_W'($urandom_range(0, 20));
            ph_target = longint'($urandom_range(0, 8)) * UNITS_PER_PKT - 4 * UNITS_PER_PKT;
            case (phase)
                0: begin
                    // Nominal pacing: one packet per tick, alert on any lead.
                    ph_rate  = RATE_W'(UNITS_PER_PKT);
                    ph_stuff = 1'b1;
                    ph_thr   = 1'b1;
                    ph_limit = '0;
                    ph_cool  = '0;
                end
                2: begin
                    // Slowest nonzero rate with both reporting flags off.
                    ph_rate  = 1;
                    ph_stuff = 1'b0;
                    ph_thr   = 1'b0;
                end
                NUM_PHASES - 2: begin
                    // Pacing disabled; ticks still run the cooldown down.
                    ph_rate = '0;
                end
                NUM_PHASES - 1: begin
                    // Every register at its top; hover near the null-packet cap.
                    ph_rate   = '1;
                    ph_stuff  = 1'b1;
                    ph_thr    = 1'b1;
                    ph_limit  = '1;
                    ph_cool   = '1;
                    ph_target = 66000 * UNITS_PER_PKT;
                end
                default: ;
            endcase
            configure(ph_rate, ph_stuff, ph_thr, ph_limit, ph_cool);
            queue_random_items(ph_target);
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d tick and %0d account beats over %0d register settings.",
                 tick_beats, acct_beats, NUM_PHASES + 4);
        $display("Checked %0d results: %0d alerts, %0d throttled, %0d capped stuff counts.",
                 results_seen, alerts_seen, throttled, due_capped);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
